// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: assertion macros for the LED cell breathing fader.
// Clocked assertions with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define LCBF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define LCBF_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/lcbf_pkg.sv =====
// ----------------------------------------------------------------------------
// lcbf_pkg: shared types and constants of the LED cell breathing fader.
// Item and result layouts, per-cell state record, register indexes, resets.
// ----------------------------------------------------------------------------
package lcbf_pkg;

  // Input item of one transfer on the start channel.
  typedef struct packed {
    logic        kind;
    logic [4:0]  cell_index;
    logic [15:0] random_word;
  } in_item_t;

  // Result item, shown for one cycle with the strobe.
  typedef struct packed {
    logic [4:0] out_cell;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  // State held for every cell in the cell memory.
  typedef struct packed {
    logic       rising;
    logic [7:0] lower_turn;
    logic [7:0] upper_turn;
    logic [7:0] level;
  } cell_state_t;

  // Item kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_INIT = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HUE        = 2'd0;
  localparam logic [1:0] CFG_SATURATION = 2'd1;
  localparam logic [1:0] CFG_FADE_STEP  = 2'd2;

  // Register reset values.
  localparam logic [8:0] HUE_RESET  = 9'd0;
  localparam logic [7:0] SAT_RESET  = 8'd255;
  localparam logic [7:0] STEP_RESET = 8'd5;

  // Number of cells that the five-bit cell index can address.
  localparam int unsigned CELL_SPAN = 32;

  // Brightness ceiling and the window of a re-initialising draw (10 up to 99).
  localparam logic [7:0] LEVEL_FULL = 8'd255;
  localparam logic [7:0] INIT_LO    = 8'd10;
  localparam logic [7:0] INIT_SPAN  = 8'd90;

  // Hue sectors: h/60 by multiplying with 1093/65536, exact for any 9-bit hue.
  localparam int unsigned SECTOR_DEG = 60;
  localparam int unsigned SECTORS    = 6;
  localparam logic [10:0] HUE_RECIP  = 11'd1093;
  // 255/60 is exactly 17/4.
  localparam logic [9:0]  F_SCALE    = 10'd17;

endpackage

// ===== design/lcbf_ram.sv =====
// ----------------------------------------------------------------------------
// lcbf_ram: generic single-port-write, single-port-read synchronous RAM.
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module lcbf_ram #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/led_cell_breathing_fader.sv =====
// ----------------------------------------------------------------------------
// led_cell_breathing_fader: per-cell LED breathing fader with HSV colouring.
// Each start transfer gives one result strobe. Distinct cells transfer every cycle unless
// the settle counter holds busy; a cell still in the 5-stage read-modify-write of the cell
// memory holds busy until written. Reset clears all cells at once by valid flags; busy
// stays high after reset or a configuration write while the hue terms are recomputed.
// ----------------------------------------------------------------------------
module led_cell_breathing_fader #(
  parameter int unsigned CELLS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lcbf_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output lcbf_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_data
);

  localparam int unsigned DEPTH = (CELLS < lcbf_pkg::CELL_SPAN) ? CELLS : lcbf_pkg::CELL_SPAN;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW    = $bits(lcbf_pkg::cell_state_t);
  localparam logic [2:0] SETTLE_CYCLES = 3'd4;

  // Hue sectors in order around the colour wheel; the last one is the default arm.
  localparam logic [2:0] SEC_RED_YELLOW   = 3'd0;
  localparam logic [2:0] SEC_YELLOW_GREEN = 3'd1;
  localparam logic [2:0] SEC_GREEN_CYAN   = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLUE    = 3'd3;
  localparam logic [2:0] SEC_BLUE_MAGENTA = 3'd4;

  typedef enum logic [1:0] {DRAW_NONE, DRAW_LOWER, DRAW_UPPER} draw_sel_t;

  // Per-item record carried down the pipeline.
  typedef struct packed {
    logic [4:0]            cell_id;
    logic                  inr;
    lcbf_pkg::cell_state_t ent;
    draw_sel_t             sel;
    logic [7:0]            base;
    logic                  div;
    logic [7:0]            dvs;
  } trip_t;

  // x/255 for x up to 255*255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  // Four restoring remainder steps, most significant word bit first.
  function automatic logic [7:0] rem_step4(input logic [7:0] rem, input logic [3:0] bits,
                                           input logic [7:0] d);
    logic [8:0] r;
    logic [7:0] acc;
    acc = rem;
    for (int i = 3; i >= 0; i--) begin
      r = {acc, bits[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
      end
      acc = r[7:0];
    end
    return acc;
  endfunction

  // Configuration registers and settle counter.
  logic [8:0] hue_r;
  logic [7:0] sat_r;
  logic [7:0] step_r;
  logic [2:0] settle_r;
  logic       cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r    <= lcbf_pkg::HUE_RESET;
      sat_r    <= lcbf_pkg::SAT_RESET;
      step_r   <= lcbf_pkg::STEP_RESET;
      settle_r <= SETTLE_CYCLES;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lcbf_pkg::CFG_HUE:        hue_r  <= cfg_data;
          lcbf_pkg::CFG_SATURATION: sat_r  <= cfg_data[7:0];
          lcbf_pkg::CFG_FADE_STEP:  step_r <= cfg_data[7:0];
          default: ;
        endcase
        settle_r <= SETTLE_CYCLES;
      end else if (settle_r != 3'd0) begin
        settle_r <= settle_r - 3'd1;
      end
    end
  end

  // Hue and saturation terms shared by every cell, rebuilt through hq_r, f_r, fsp_r and kq_r/kt_r.
  logic [19:0] hue_prod;
  logic [3:0]  hq_r;
  logic [5:0]  hrem;
  logic [9:0]  f_scaled;
  logic [2:0]  sector_nxt;
  logic [7:0]  f_r;
  logic [2:0]  sector_r;
  logic [15:0] fsp_r;
  logic [15:0] gsp_r;
  logic [7:0]  ps_r;
  logic [7:0]  kq_r;
  logic [7:0]  kt_r;

  assign hue_prod   = 20'(hue_r) * 20'(lcbf_pkg::HUE_RECIP);
  assign hrem       = 6'(hue_r - 9'(hq_r) * 9'(lcbf_pkg::SECTOR_DEG));
  assign f_scaled   = {4'd0, hrem} * lcbf_pkg::F_SCALE;
  assign sector_nxt = (hq_r >= 4'(lcbf_pkg::SECTORS)) ? 3'(hq_r - 4'(lcbf_pkg::SECTORS))
                                                       : hq_r[2:0];

  always_ff @(posedge clk) begin
    hq_r     <= hue_prod[19:16];
    f_r      <= f_scaled[9:2];
    sector_r <= sector_nxt;
    fsp_r    <= 16'(f_r) * 16'(sat_r);
    gsp_r    <= 16'(lcbf_pkg::LEVEL_FULL - f_r) * 16'(sat_r);
    ps_r     <= lcbf_pkg::LEVEL_FULL - sat_r;
    kq_r     <= lcbf_pkg::LEVEL_FULL - div255(fsp_r);
    kt_r     <= lcbf_pkg::LEVEL_FULL - div255(gsp_r);
  end

  // Pipeline registers.
  logic        s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic        s1_kind_r;
  logic [4:0]  s1_cell_r;
  logic [15:0] s1_word_r;
  logic        s1_inr_r;
  trip_t       s2_trip_r, s3_trip_r, s4_trip_r, s5_trip_r;
  logic [15:0] s2_word_r;
  logic [11:0] s3_word_r;
  logic [7:0]  s4_word_r;
  logic [3:0]  s5_word_r;
  logic [7:0]  s3_rem_r, s4_rem_r, s5_rem_r;
  logic [15:0] s3_mp_r, s3_mq_r, s3_mt_r;
  logic [7:0]  s4_red_r, s4_green_r, s4_blue_r;
  logic [7:0]  s5_red_r, s5_green_r, s5_blue_r;
  logic        out_strobe_r;
  lcbf_pkg::out_item_t out_item_r;
  logic [DEPTH-1:0] valid_r;

  logic          accept;
  logic          in_inr;
  logic          hit;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  lcbf_pkg::cell_state_t wr_ent;

  // Interlock: a cell may not enter while an earlier item for it awaits write-back.
  assign hit = (s1_v_r && s1_cell_r == in_item.cell_index) ||
               (s2_v_r && s2_trip_r.cell_id == in_item.cell_index) ||
               (s3_v_r && s3_trip_r.cell_id == in_item.cell_index) ||
               (s4_v_r && s4_trip_r.cell_id == in_item.cell_index) ||
               (s5_v_r && s5_trip_r.cell_id == in_item.cell_index);
  assign busy    = (settle_r != 3'd0) || hit;
  assign accept  = start && !busy;
  assign in_inr  = 32'(in_item.cell_index) < CELLS;
  assign rd_addr = in_inr ? in_item.cell_index[AW-1:0] : '0;

  lcbf_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_cell_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_ent),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      s4_v_r       <= 1'b0;
      s5_v_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      valid_r      <= '0;
    end else begin
      s1_v_r       <= accept;
      s2_v_r       <= s1_v_r;
      s3_v_r       <= s2_v_r;
      s4_v_r       <= s3_v_r;
      s5_v_r       <= s4_v_r;
      out_strobe_r <= s5_v_r;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Stage 1: state read back; decide the turn and the new level.
  lcbf_pkg::cell_state_t cur;
  logic [8:0] lv_s;
  logic [8:0] lo_s;
  logic       turn_fall;
  logic       turn_rise;
  trip_t      trip_nxt;

  always_comb begin
    cur = (s1_inr_r && valid_r[s1_cell_r[AW-1:0]]) ? lcbf_pkg::cell_state_t'(rd_data) : '0;
    lv_s = {1'b0, cur.level} + {1'b0, step_r};
    lo_s = {1'b0, cur.lower_turn} + {1'b0, step_r};
    turn_fall = cur.rising && (lv_s >= {1'b0, cur.upper_turn});
    turn_rise = !cur.rising && ({1'b0, cur.level} <= lo_s);
    trip_nxt.cell_id = s1_cell_r;
    trip_nxt.inr  = s1_inr_r;
    trip_nxt.ent  = cur;
    trip_nxt.sel  = DRAW_NONE;
    trip_nxt.base = 8'd0;
    trip_nxt.div  = 1'b0;
    trip_nxt.dvs  = 8'd0;
    if (s1_kind_r == lcbf_pkg::KIND_INIT) begin
      trip_nxt.ent.rising     = 1'b0;
      trip_nxt.ent.lower_turn = 8'd0;
      trip_nxt.ent.level      = 8'd0;
      trip_nxt.sel  = DRAW_UPPER;
      trip_nxt.base = lcbf_pkg::INIT_LO;
      trip_nxt.div  = 1'b1;
      trip_nxt.dvs  = lcbf_pkg::INIT_SPAN;
    end else begin
      if (turn_fall) begin
        trip_nxt.ent.rising = 1'b0;
        trip_nxt.sel  = DRAW_LOWER;
        trip_nxt.div  = cur.upper_turn > step_r;
        trip_nxt.dvs  = cur.upper_turn - step_r;
      end else if (turn_rise) begin
        trip_nxt.ent.rising = 1'b1;
        trip_nxt.sel  = DRAW_UPPER;
        trip_nxt.base = lo_s[7:0];
        // No draw once the new lower bound reaches full brightness.
        trip_nxt.div  = lo_s < {1'b0, lcbf_pkg::LEVEL_FULL};
        trip_nxt.dvs  = lcbf_pkg::LEVEL_FULL - lo_s[7:0];
      end
      trip_nxt.ent.level = trip_nxt.ent.rising ? cur.level + step_r : cur.level - step_r;
    end
  end

  // Stage 3 colour: scale the shared terms by the level and pick by sector.
  logic [7:0] c_v, c_p, c_q, c_t;
  logic [7:0] red_nxt, green_nxt, blue_nxt;

  always_comb begin
    c_v = s3_trip_r.ent.level;
    c_p = div255(s3_mp_r);
    c_q = div255(s3_mq_r);
    c_t = div255(s3_mt_r);
    unique case (sector_r)
      SEC_RED_YELLOW:   begin red_nxt = c_v; green_nxt = c_t; blue_nxt = c_p; end
      SEC_YELLOW_GREEN: begin red_nxt = c_q; green_nxt = c_v; blue_nxt = c_p; end
      SEC_GREEN_CYAN:   begin red_nxt = c_p; green_nxt = c_v; blue_nxt = c_t; end
      SEC_CYAN_BLUE:    begin red_nxt = c_p; green_nxt = c_q; blue_nxt = c_v; end
      SEC_BLUE_MAGENTA: begin red_nxt = c_t; green_nxt = c_p; blue_nxt = c_v; end
      default:          begin red_nxt = c_v; green_nxt = c_p; blue_nxt = c_q; end
    endcase
    if (!s3_trip_r.inr) begin
      red_nxt   = 8'd0;
      green_nxt = 8'd0;
      blue_nxt  = 8'd0;
    end
  end

  // Stage 5: last remainder bits, the drawn turning point and write-back.
  logic [7:0] rem_fin;
  logic [7:0] turn_val;

  always_comb begin
    rem_fin  = rem_step4(s5_rem_r, s5_word_r, s5_trip_r.dvs);
    turn_val = s5_trip_r.base + (s5_trip_r.div ? rem_fin : 8'd0);
    wr_ent   = s5_trip_r.ent;
    unique case (s5_trip_r.sel)
      DRAW_LOWER: wr_ent.lower_turn = turn_val;
      DRAW_UPPER: wr_ent.upper_turn = turn_val;
      default: ;
    endcase
  end

  assign wr_en   = s5_v_r && s5_trip_r.inr;
  assign wr_addr = s5_trip_r.cell_id[AW-1:0];

  // Payload registers of the pipeline.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= in_item.kind;
      s1_cell_r <= in_item.cell_index;
      s1_word_r <= in_item.random_word;
      s1_inr_r  <= in_inr;
    end
    s2_trip_r <= trip_nxt;
    s2_word_r <= s1_word_r;

    s3_trip_r <= s2_trip_r;
    s3_word_r <= s2_word_r[11:0];
    s3_rem_r  <= rem_step4(8'd0, s2_word_r[15:12], s2_trip_r.dvs);
    s3_mp_r   <= 16'(ps_r) * 16'(s2_trip_r.ent.level);
    s3_mq_r   <= 16'(kq_r) * 16'(s2_trip_r.ent.level);
    s3_mt_r   <= 16'(kt_r) * 16'(s2_trip_r.ent.level);

    s4_trip_r  <= s3_trip_r;
    s4_word_r  <= s3_word_r[7:0];
    s4_rem_r   <= rem_step4(s3_rem_r, s3_word_r[11:8], s3_trip_r.dvs);
    s4_red_r   <= red_nxt;
    s4_green_r <= green_nxt;
    s4_blue_r  <= blue_nxt;

    s5_trip_r  <= s4_trip_r;
    s5_word_r  <= s4_word_r[3:0];
    s5_rem_r   <= rem_step4(s4_rem_r, s4_word_r[7:4], s4_trip_r.dvs);
    s5_red_r   <= s4_red_r;
    s5_green_r <= s4_green_r;
    s5_blue_r  <= s4_blue_r;

    if (s5_v_r) begin
      out_item_r.out_cell <= s5_trip_r.cell_id;
      out_item_r.red      <= s5_red_r;
      out_item_r.green    <= s5_green_r;
      out_item_r.blue     <= s5_blue_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

// ===== design/lcbf_checker.sv =====
// ----------------------------------------------------------------------------
// lcbf_checker: port-level assertions for the LED cell breathing fader.
// Checks result timing against start transfers and the hold-off after writes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcbf_checker #(
  parameter int unsigned CELLS = 32
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input lcbf_pkg::in_item_t  in_item,
  input logic                out_strobe,
  input lcbf_pkg::out_item_t out_item,
  input logic                cfg_valid,
  input logic                cfg_ready
);

  logic in_xfer;
  logic cfg_xfer;

  assign in_xfer  = start && !busy;
  assign cfg_xfer = cfg_valid && cfg_ready;

  property p_result_follows;
    in_xfer |-> ##6 (out_strobe && out_item.out_cell == $past(in_item.cell_index, 6));
  endproperty

  property p_outside_dark;
    out_strobe && 32'(out_item.out_cell) >= CELLS |->
      (out_item.red == 8'd0 && out_item.green == 8'd0 && out_item.blue == 8'd0);
  endproperty

  // Reset empties the pipeline, so no result follows a reset cycle.
  `LCBF_ASSERT_NR(a_reset_no_result, clk, (!rst_n |=> !out_strobe), "strobe after reset")

  // Every transfer gives its result strobe, for the same cell.
  `LCBF_ASSERT(a_result_follows, clk, rst_n, p_result_follows, "result missing or misrouted")

  // No result without a matching earlier transfer.
  `LCBF_ASSERT(a_no_spurious, clk, rst_n, (out_strobe |-> $past(in_xfer, 6)), "result without a transfer")

  // Shared colour terms are rebuilt after a write, so the block holds off.
  `LCBF_ASSERT(a_cfg_holdoff, clk, rst_n, (cfg_xfer |=> busy), "no hold-off after a write")

  // A cell outside the strip reports black.
  `LCBF_ASSERT(a_outside_dark, clk, rst_n, p_outside_dark, "colour for a cell off the strip")

endmodule

bind led_cell_breathing_fader lcbf_checker #(.CELLS(CELLS)) u_lcbf_checker (.*);

// ===== dv/led_cell_breathing_fader_test.sv =====
// ----------------------------------------------------------------------------
// led_cell_breathing_fader_test: self-checking bench for the breathing fader.
// Items are driven through the start/busy handshake. Each accepted item is run
// through a local model of the cell memory and the HSV colouring. Every strobed
// colour is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module led_cell_breathing_fader_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = 32;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  lcbf_pkg::in_item_t  in_item = '0;
  logic                out_strobe;
  lcbf_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = lcbf_pkg::CFG_HUE;
  logic [8:0]          cfg_data = '0;

  led_cell_breathing_fader #(.CELLS(CELLS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Local copy of the registers and the cell memory.
  logic [8:0]            colour_hue = lcbf_pkg::HUE_RESET;
  logic [7:0]            colour_sat = lcbf_pkg::SAT_RESET;
  logic [7:0]            breath_step = lcbf_pkg::STEP_RESET;
  lcbf_pkg::cell_state_t cells [CELLS];

  lcbf_pkg::out_item_t expected_colours [$];
  int          sender_idle_pct = 0;
  int          fault_count = 0;
  int          items_sent = 0;
  int          inits_sent = 0;
  int          colours_checked = 0;
  int          turn_count = 0;

  // Colour and step settings visited by the random phases, three per phase.
  int unsigned hue_plan  [9] = '{0, 359, 120, 511, 200, 45, 300, 400, 180};
  int unsigned sat_plan  [9] = '{255, 0, 200, 128, 255, 90, 1, 255, 77};
  int unsigned step_plan [9] = '{5, 1, 17, 255, 0, 3, 64, 9, 200};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [7:0] draw_turn(int lo_bound, int hi_bound, logic [15:0] word);
    int r;
    r = lo_bound;
    if (hi_bound > lo_bound) begin
      r = lo_bound + int'(word) % (hi_bound - lo_bound);
    end
    return 8'(r);
  endfunction

  function automatic logic [23:0] hsv_colour(int unsigned h, int unsigned s, int unsigned v);
    int unsigned f, p, q, t;
    logic [7:0]  r, g, b;
    f = (h % lcbf_pkg::SECTOR_DEG) * 255 / lcbf_pkg::SECTOR_DEG;
    p = (255 - s) * v / 255;
    q = (255 - f * s / 255) * v / 255;
    t = (255 - (255 - f) * s / 255) * v / 255;
    unique case ((h / lcbf_pkg::SECTOR_DEG) % lcbf_pkg::SECTORS)
      0: begin r = 8'(v); g = 8'(t); b = 8'(p); end
      1: begin r = 8'(q); g = 8'(v); b = 8'(p); end
      2: begin r = 8'(p); g = 8'(v); b = 8'(t); end
      3: begin r = 8'(p); g = 8'(q); b = 8'(v); end
      4: begin r = 8'(t); g = 8'(p); b = 8'(v); end
      default: begin r = 8'(v); g = 8'(p); b = 8'(q); end
    endcase
    return {r, g, b};
  endfunction

  // Updates the addressed cell and returns the colour it should report.
  function automatic lcbf_pkg::out_item_t predict_colour(lcbf_pkg::in_item_t it);
    lcbf_pkg::out_item_t   res;
    lcbf_pkg::cell_state_t c;
    int                    s, lv, lo, hi;
    res = '0;
    res.out_cell = it.cell_index;
    if (int'(it.cell_index) >= CELLS) begin
      return res;
    end
    c = cells[it.cell_index];
    if (it.kind == lcbf_pkg::KIND_INIT) begin
      c.rising = 1'b0;
      c.lower_turn = '0;
      c.level = '0;
      c.upper_turn = draw_turn(int'(lcbf_pkg::INIT_LO),
                               int'(lcbf_pkg::INIT_LO) + int'(lcbf_pkg::INIT_SPAN),
                               it.random_word);
    end else begin
      s = int'(breath_step);
      lv = int'(c.level);
      lo = int'(c.lower_turn);
      hi = int'(c.upper_turn);
      if (c.rising && lv >= hi - s) begin
        c.rising = 1'b0;
        c.lower_turn = draw_turn(0, hi - s, it.random_word);
        turn_count++;
      end else if (!c.rising && lv <= lo + s) begin
        c.rising = 1'b1;
        c.upper_turn = draw_turn(lo + s, int'(lcbf_pkg::LEVEL_FULL), it.random_word);
        turn_count++;
      end
      if (c.rising) begin
        c.level = c.level + breath_step;
      end else begin
        c.level = c.level - breath_step;
      end
    end
    cells[it.cell_index] = c;
    {res.red, res.green, res.blue} = hsv_colour(32'(colour_hue), 32'(colour_sat),
                                                32'(c.level));
    return res;
  endfunction

  task automatic send_cell_item(logic kind, logic [4:0] cell_id, logic [15:0] word);
    lcbf_pkg::in_item_t it;
    it.kind = kind;
    it.cell_index = cell_id;
    it.random_word = word;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    expected_colours.push_back(predict_colour(it));
    items_sent++;
    if (kind == lcbf_pkg::KIND_INIT) begin
      inits_sent++;
    end
  endtask

  // Holds the sender off until every colour has come back and the pipe is empty.
  task automatic settle_block();
    start <= 1'b0;
    while (expected_colours.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    unique case (idx)
      lcbf_pkg::CFG_HUE:        colour_hue = data;
      lcbf_pkg::CFG_SATURATION: colour_sat = data[7:0];
      lcbf_pkg::CFG_FADE_STEP:  breath_step = data[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // The unused top bit of the data word is set at random for the 8-bit registers.
  task automatic apply_settings(int unsigned hue, int unsigned sat, int unsigned step);
    settle_block();
    write_register(lcbf_pkg::CFG_HUE, 9'(hue));
    write_register(lcbf_pkg::CFG_SATURATION, {1'($urandom_range(1)), 8'(sat)});
    write_register(lcbf_pkg::CFG_FADE_STEP, {1'($urandom_range(1)), 8'(step)});
  endtask

  task automatic test_reset_state();
    send_cell_item(lcbf_pkg::KIND_TICK, 5'd0, 16'h0000);
    send_cell_item(lcbf_pkg::KIND_TICK, 5'd31, 16'hffff);
    send_cell_item(lcbf_pkg::KIND_INIT, 5'd0, 16'hffff);
    send_cell_item(lcbf_pkg::KIND_INIT, 5'd31, 16'h0000);
  endtask

  // One cell through both turns with a large step, then a full-scale step so
  // that the level wraps and the upper draw lands at the top of the range.
  task automatic test_turn_extremes();
    apply_settings(90, 255, 100);
    send_cell_item(lcbf_pkg::KIND_INIT, 5'd2, 16'd89);
    send_cell_item(lcbf_pkg::KIND_TICK, 5'd2, 16'd154);
    send_cell_item(lcbf_pkg::KIND_TICK, 5'd2, 16'd0);
    send_cell_item(lcbf_pkg::KIND_TICK, 5'd2, 16'd153);
    send_cell_item(lcbf_pkg::KIND_TICK, 5'd2, 16'd1);
    apply_settings(90, 255, 255);
    send_cell_item(lcbf_pkg::KIND_TICK, 5'd2, 16'hffff);
    send_cell_item(lcbf_pkg::KIND_TICK, 5'd2, 16'h0000);
    send_cell_item(lcbf_pkg::KIND_TICK, 5'd2, 16'h5a5a);
  endtask

  task automatic test_colour_sectors();
    apply_settings(359, 0, 5);
    send_cell_item(lcbf_pkg::KIND_TICK, 5'd2, 16'h1234);
    apply_settings(511, 255, 5);
    send_cell_item(lcbf_pkg::KIND_TICK, 5'd31, 16'h8000);
    for (int sector = 0; sector < 6; sector++) begin
      apply_settings(sector * 60 + 30, 128, 5);
      send_cell_item(lcbf_pkg::KIND_TICK, 5'd2, 16'(sector));
    end
  endtask

  task automatic test_random_breathing(int idle_pct, int plan_base);
    int          roll;
    logic        kind;
    logic [4:0]  cell_id;
    logic [15:0] word;
    sender_idle_pct = idle_pct;
    for (int k = 0; k < 3; k++) begin
      apply_settings(hue_plan[plan_base + k], sat_plan[plan_base + k],
                     step_plan[plan_base + k]);
      for (int i = 0; i < 155; i++) begin
        if (i == 77) begin
          settle_block();
        end
        kind = ($urandom_range(99) < 8) ? lcbf_pkg::KIND_INIT : lcbf_pkg::KIND_TICK;
        // Most traffic goes to a few cells so that they breathe through many turns.
        cell_id = ($urandom_range(99) < 75) ? 5'($urandom_range(5)) : 5'($urandom_range(31));
        roll = $urandom_range(99);
        if (roll < 5) begin
          word = 16'h0000;
        end else if (roll < 10) begin
          word = 16'hffff;
        end else begin
          word = 16'($urandom_range(16'hffff));
        end
        send_cell_item(kind, cell_id, word);
      end
    end
  endtask

  task automatic report_field(string field, int want, int got);
    if (want != got) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    lcbf_pkg::out_item_t want;
    if (rst_n && out_strobe) begin
      if (expected_colours.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected colour, expected none, actual cell %0d rgb %h",
                 $time, out_item.out_cell, {out_item.red, out_item.green, out_item.blue});
      end else begin
        want = expected_colours.pop_front();
        report_field("out_cell", int'(want.out_cell), int'(out_item.out_cell));
        report_field("red", int'(want.red), int'(out_item.red));
        report_field("green", int'(want.green), int'(out_item.green));
        report_field("blue", int'(want.blue), int'(out_item.blue));
        colours_checked++;
      end
    end
  end

  initial begin
    for (int c = 0; c < CELLS; c++) begin
      cells[c] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_turn_extremes();
    test_colour_sectors();
    test_random_breathing(15, 0);
    test_random_breathing(79, 3);
    test_random_breathing(0, 6);
    settle_block();
    if (expected_colours.size() != 0) begin
      fault_count++;
      $display("%0t: %0d colours never arrived", $time, expected_colours.size());
    end
    $display("Sent %0d cell updates (%0d re-initialisations), checked %0d colours,",
             items_sent, inits_sent, colours_checked);
    $display("saw %0d direction turns across nineteen colour and step settings.", turn_count);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
